FILE: sv/csvs_pkg.sv
`timescale 1ns / 1ps
// Package for the CSV stream field splitter.
// Holds parser states, character codes, the result beat type and helpers.
// No dependencies.
package csvs_pkg;

    localparam logic [7:0] CH_CR         = 8'd13;
    localparam logic [7:0] CH_LF         = 8'd10;
    localparam logic [7:0] CH_QUOTE      = 8'd34;
    localparam logic [7:0] DELIM_RESET   = 8'd44;

    typedef enum logic [2:0] {
        ST_LINE_START  = 3'd0,
        ST_FIELD_START = 3'd1,
        ST_REGULAR     = 3'd2,
        ST_QUOTED      = 3'd3,
        ST_QUOTE_SEEN  = 3'd4,
        ST_CR_SEEN     = 3'd5
    } parse_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       row_end;
        logic       last;
    } result_t;

    // Results of one input byte: up to two beats, res0 first.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

    function automatic result_t mk_content(input logic [7:0] b);
        result_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    function automatic result_t mk_mark(input logic fe, input logic re);
        result_t r;
        r           = '0;
        r.field_end = fe;
        r.row_end   = re;
        return r;
    endfunction

endpackage

FILE: sv/csvs_parser.sv
`timescale 1ns / 1ps
// Parser state machine of the CSV stream field splitter.
// Computes the result beats of one byte and advances the parse state.
// Depends on csvs_pkg.
module csvs_parser
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    input  logic [7:0] delimiter,
    output step_t      step
);

    parse_state_t state_reg;
    parse_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LINE_START;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    logic         is_cr;
    logic         is_lf;
    logic         is_q;
    logic         is_d;
    result_t      reg_res;
    parse_state_t reg_nxt;
    logic [1:0]   fs_cnt;
    parse_state_t fs_nxt;
    logic [1:0]   ls_cnt;
    result_t      ls_res;
    parse_state_t ls_nxt;

    assign is_cr = (data_byte == CH_CR);
    assign is_lf = (data_byte == CH_LF);
    assign is_q  = (data_byte == CH_QUOTE);
    assign is_d  = (data_byte == delimiter);

    // unquoted field byte: always one beat
    always_comb
    begin
        if (is_cr)
        begin
            reg_res = mk_mark(1'b1, 1'b1);
            reg_nxt = ST_CR_SEEN;
        end
        else if (is_lf)
        begin
            reg_res = mk_mark(1'b1, 1'b1);
            reg_nxt = ST_LINE_START;
        end
        else if (is_d)
        begin
            reg_res = mk_mark(1'b1, 1'b0);
            reg_nxt = ST_FIELD_START;
        end
        else
        begin
            reg_res = mk_content(data_byte);
            reg_nxt = ST_REGULAR;
        end
    end

    // field start: an opening quote gives no beat
    assign fs_cnt = is_q ? 2'd0 : 2'd1;
    assign fs_nxt = is_q ? ST_QUOTED : reg_nxt;

    always_comb
    begin
        if (is_cr)
        begin
            ls_cnt = 2'd1;
            ls_res = mk_mark(1'b0, 1'b1);
            ls_nxt = ST_CR_SEEN;
        end
        else if (is_lf)
        begin
            ls_cnt = 2'd1;
            ls_res = mk_mark(1'b0, 1'b1);
            ls_nxt = ST_LINE_START;
        end
        else
        begin
            ls_cnt = fs_cnt;
            ls_res = reg_res;
            ls_nxt = fs_nxt;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step       = '0;
        if (end_of_input)
        begin
            if (state_reg inside {ST_FIELD_START, ST_REGULAR, ST_QUOTED, ST_QUOTE_SEEN})
            begin
                step.count = 2'd1;
                step.res0  = mk_mark(1'b1, 1'b1);
            end
            state_next = ST_LINE_START;
        end
        else
        begin
            case (state_reg)
                ST_FIELD_START:
                begin
                    step.count = fs_cnt;
                    step.res0  = reg_res;
                    state_next = fs_nxt;
                end
                ST_REGULAR:
                begin
                    step.count = 2'd1;
                    step.res0  = reg_res;
                    state_next = reg_nxt;
                end
                ST_QUOTED:
                begin
                    if (is_q)
                    begin
                        state_next = ST_QUOTE_SEEN;
                    end
                    else
                    begin
                        step.count = 2'd1;
                        step.res0  = mk_content(data_byte);
                    end
                end
                ST_QUOTE_SEEN:
                begin
                    if (is_cr || is_lf || is_d)
                    begin
                        step.count = 2'd1;
                        step.res0  = reg_res;
                        state_next = reg_nxt;
                    end
                    else if (is_q)
                    begin
                        step.count = 2'd1;
                        step.res0  = mk_content(CH_QUOTE);
                        state_next = ST_QUOTED;
                    end
                    else
                    begin
                        step.count = 2'd2;
                        step.res0  = mk_content(CH_QUOTE);
                        step.res1  = mk_content(data_byte);
                        state_next = ST_QUOTED;
                    end
                end
                ST_CR_SEEN:
                begin
                    if (is_lf)
                    begin
                        state_next = ST_LINE_START;
                    end
                    else
                    begin
                        step.count = ls_cnt;
                        step.res0  = ls_res;
                        state_next = ls_nxt;
                    end
                end
                default:
                begin
                    step.count = ls_cnt;
                    step.res0  = ls_res;
                    state_next = ls_nxt;
                end
            endcase
        end
        step.res0.last = (step.count == 2'd1);
        step.res1.last = 1'b1;
    end

endmodule

FILE: sv/csvs_out_queue.sv
`timescale 1ns / 1ps
// Two-entry result queue of the CSV stream field splitter.
// Takes up to two beats per cycle and hands out one; depends on csvs_pkg.
module csvs_out_queue
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output logic       head_valid,
    output result_t    head,
    output logic [1:0] room
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    q0_reg;
    result_t    q0_next;
    result_t    q1_reg;
    result_t    q1_next;
    logic [1:0] kept;
    result_t    kept0;

    assign head_valid = (count_reg != 2'd0);
    assign head       = q0_reg;
    assign room       = 2'd2 - count_reg + {1'b0, pop};

    always_comb
    begin
        kept  = count_reg - {1'b0, pop};
        kept0 = pop ? q1_reg : q0_reg;
        if (kept == 2'd0)
        begin
            q0_next    = push0;
            q1_next    = push1;
            count_next = push_cnt;
        end
        else
        begin
            q0_next    = kept0;
            q1_next    = (kept == 2'd2) ? q1_reg : push0;
            count_next = kept + push_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

FILE: sv/csv_stream_field_splitter.sv
`timescale 1ns / 1ps
// CSV stream field splitter: one input byte per beat, result beats carry
// content bytes and field-end / row-end marks. An accepted byte is registered in
// the input stage; its result beats pass through the result queue to the output.
// Throughput: one byte per cycle while the output is not stalled; a byte with
// two results (after a lone quote in a quoted field) can wait for room for both.
// Reset: delimiter to ',', parser to line start, input and result stages empty.
module csv_stream_field_splitter
    import csvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,     // delimiter
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // data_byte
    input  logic       s_axis_tuser,  // end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // out_byte
    output logic [2:0] m_axis_tuser,  // byte_valid, field_end, row_end
    output logic       m_axis_tlast
);

    logic [7:0] delimiter_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    step_t      step;
    logic       consume;
    logic       pop;
    logic [1:0] room;
    result_t    head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
        end
        else if (cfg_we)
        begin
            delimiter_reg <= cfg_wdata;
        end
    end

    assign consume       = in_valid_reg && (step.count <= room);
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eoi_reg  <= s_axis_tuser;
        end
    end

    csvs_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (consume),
        .data_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .delimiter    (delimiter_reg),
        .step         (step)
    );

    assign pop = m_axis_tvalid && m_axis_tready;

    csvs_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (consume ? step.count : 2'd0),
        .push0      (step.res0),
        .push1      (step.res1),
        .pop        (pop),
        .head_valid (m_axis_tvalid),
        .head       (head),
        .room       (room)
    );

    assign m_axis_tdata = head.out_byte;
    assign m_axis_tuser = {head.row_end, head.field_end, head.byte_valid};
    assign m_axis_tlast = head.last;

endmodule

FILE: sv/csvs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the CSV stream field splitter.
// Bound to csv_stream_field_splitter; depends on nothing else.
module csvs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [2:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    a_content_or_mark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
        else $error("beat carries content and a mark");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("mark beat with nonzero byte");

    a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1] || m_axis_tuser[2]) |-> m_axis_tlast)
        else $error("mark beat not last of its byte");

endmodule

bind csv_stream_field_splitter csvs_checker u_csvs_checker (.*);

FILE: tb/sv/csv_stream_field_splitter_test.sv
`timescale 1ns / 1ps
// Testbench for csv_stream_field_splitter: directed and random CSV text, noise and
// broken quoting, checked beat by beat; random stalls on both streams save the last phase.
// Depends on csvs_pkg and the csv_stream_field_splitter RTL.
module csv_stream_field_splitter_test;
    import csvs_pkg::*;

    class csv_split_tracker;
        logic [7:0]   delim;
        parse_state_t state;
        result_t      awaited[$];
        result_t      fresh[$];
        int           fails;

        function new();
            delim = DELIM_RESET;
            state = ST_LINE_START;
            fails = 0;
        endfunction

        function void emit(input logic [7:0] b, input logic valid, input logic fe,
                           input logic re);
            result_t r;
            r            = '0;
            r.out_byte   = valid ? b : 8'h00;
            r.byte_valid = valid;
            r.field_end  = fe;
            r.row_end    = re;
            fresh.insert(fresh.size(), r);
        endfunction

        function void unquoted(input logic [7:0] b);
            if (b == CH_CR)
            begin
                emit(8'h00, 1'b0, 1'b1, 1'b1);
                state = ST_CR_SEEN;
            end
            else if (b == CH_LF)
            begin
                emit(8'h00, 1'b0, 1'b1, 1'b1);
                state = ST_LINE_START;
            end
            else if (b == delim)
            begin
                emit(8'h00, 1'b0, 1'b1, 1'b0);
                state = ST_FIELD_START;
            end
            else
            begin
                emit(b, 1'b1, 1'b0, 1'b0);
                state = ST_REGULAR;
            end
        endfunction

        function void field_begin(input logic [7:0] b);
            if (b == CH_QUOTE)
                state = ST_QUOTED;
            else
                unquoted(b);
        endfunction

        function void line_begin(input logic [7:0] b);
            if (b == CH_CR)
            begin
                emit(8'h00, 1'b0, 1'b0, 1'b1);
                state = ST_CR_SEEN;
            end
            else if (b == CH_LF)
            begin
                emit(8'h00, 1'b0, 1'b0, 1'b1);
                state = ST_LINE_START;
            end
            else
                field_begin(b);
        endfunction

        function void take_byte(input logic [7:0] b, input logic eoi);
            fresh.delete();
            if (eoi)
            begin
                if (state == ST_FIELD_START || state == ST_REGULAR ||
                    state == ST_QUOTED || state == ST_QUOTE_SEEN)
                    emit(8'h00, 1'b0, 1'b1, 1'b1);
                state = ST_LINE_START;
            end
            else
            begin
                case (state)
                    ST_FIELD_START: field_begin(b);
                    ST_REGULAR:     unquoted(b);
                    ST_QUOTED:
                    begin
                        if (b == CH_QUOTE)
                            state = ST_QUOTE_SEEN;
                        else
                            emit(b, 1'b1, 1'b0, 1'b0);
                    end
                    ST_QUOTE_SEEN:
                    begin
                        if (b == CH_CR || b == CH_LF || b == delim)
                            unquoted(b);
                        else if (b == CH_QUOTE)
                        begin
                            emit(CH_QUOTE, 1'b1, 1'b0, 1'b0);
                            state = ST_QUOTED;
                        end
                        else
                        begin
                            emit(CH_QUOTE, 1'b1, 1'b0, 1'b0);
                            emit(b, 1'b1, 1'b0, 1'b0);
                            state = ST_QUOTED;
                        end
                    end
                    ST_CR_SEEN:
                    begin
                        if (b == CH_LF)
                            state = ST_LINE_START;
                        else
                            line_begin(b);
                    end
                    default:        line_begin(b);
                endcase
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                awaited.insert(awaited.size(), fresh[i]);
        endfunction

        function void compare(input string name, input logic [7:0] want,
                              input logic [7:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_beat(input logic [7:0] data, input logic [2:0] user,
                                 input logic tl);
            result_t want;
            if (awaited.size() == 0)
            begin
                $error("result beat with none expected: data %0h user %b last %b",
                       data, user, tl);
                fails++;
                return;
            end
            want = awaited.pop_front();
            compare("out_byte", want.out_byte, data);
            compare("byte_valid", 8'(want.byte_valid), 8'(user[0]));
            compare("field_end", 8'(want.field_end), 8'(user[1]));
            compare("row_end", 8'(want.row_end), 8'(user[2]));
            compare("last", 8'(want.last), 8'(tl));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    csv_split_tracker board;
    bit               calm;
    int               bytes_fed;
    logic [8:0]       script[$];

    csv_stream_field_splitter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.take_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                board.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial
    begin : sink_ready
        int run;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm || $urandom_range(0, 2) != 0)
            begin
                m_axis_tready <= 1'b1;
                run = calm ? 1 : $urandom_range(1, 40);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                run = $urandom_range(1, 19);
            end
            repeat (run - 1) @(negedge clk);
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic eoi);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= eoi;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_fed++;
    endtask

    // hold the input until every awaited beat is out and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (board.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_delimiter(input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        board.delim = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic void add(input logic [7:0] b);
        script.insert(script.size(), {1'b0, b});
    endfunction

    function automatic void add_eoi();
        script.insert(script.size(), {1'b1, 8'($urandom)});
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] d);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_CR || b == CH_LF || b == CH_QUOTE || b == d);
        return b;
    endfunction

    function automatic void compose_quoted(input logic [7:0] d);
        int len;
        len = $urandom_range(0, 6);
        add(CH_QUOTE);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    add(CH_QUOTE);
                    add(CH_QUOTE);
                end
                1:
                begin
                    add(CH_QUOTE);
                    add(plain_byte(d));
                end
                2:       add(CH_CR);
                3:       add(CH_LF);
                4:       add(d);
                default: add(plain_byte(d));
            endcase
        end
        add(CH_QUOTE);
    endfunction

    function automatic void compose_row(input logic [7:0] d);
        int nf;
        int len;
        nf = $urandom_range(0, 4);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                add(d);
            case ($urandom_range(0, 2))
                0: ;
                1:
                begin
                    len = $urandom_range(1, 6);
                    add(plain_byte(d));
                    for (int i = 1; i < len; i++)
                        add(($urandom_range(0, 7) == 0) ? CH_QUOTE : plain_byte(d));
                end
                default: compose_quoted(d);
            endcase
        end
        case ($urandom_range(0, 7))
            0, 1, 2:
            begin
                add(CH_CR);
                add(CH_LF);
            end
            3, 4:    add(CH_LF);
            5, 6:    add(CH_CR);
            default: add_eoi();
        endcase
    endfunction

    function automatic void compose_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                add_eoi();
            else
                add(8'($urandom));
        end
    endfunction

    function automatic void compose_broken(input logic [7:0] d);
        int n;
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 2))
            0:
            begin
                add(CH_QUOTE);
                for (int i = 0; i < n; i++)
                    add(plain_byte(d));
                add_eoi();
            end
            1:
            begin
                add(CH_QUOTE);
                add(plain_byte(d));
                add(CH_QUOTE);
                for (int i = 0; i <= n; i++)
                    add(plain_byte(d));
                add(CH_QUOTE);
                add(CH_LF);
            end
            default:
            begin
                for (int i = 0; i <= n; i++)
                    add(plain_byte(d));
                add_eoi();
            end
        endcase
    endfunction

    task automatic run_directed();
        logic [8:0] items[$];
        items = '{
            {1'b0, 8'h00}, {1'b0, DELIM_RESET}, {1'b0, 8'hFF}, {1'b0, CH_QUOTE},
            {1'b0, CH_LF}, {1'b0, CH_CR}, {1'b0, CH_LF}, {1'b0, CH_QUOTE},
            {1'b0, DELIM_RESET}, {1'b0, CH_CR}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
            {1'b0, CH_QUOTE}, {1'b0, 8'h7A}, {1'b0, CH_QUOTE}, {1'b0, DELIM_RESET},
            {1'b0, DELIM_RESET}, {1'b0, CH_CR}, {1'b0, 8'h71}, {1'b1, 8'hA5},
            {1'b1, 8'h00}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_CR},
            {1'b1, 8'h5A}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE}, {1'b0, CH_LF},
            {1'b0, CH_QUOTE}, {1'b1, 8'hFF}
        };
        foreach (items[i])
            push_beat(items[i][7:0], items[i][8]);
    endtask

    task automatic run_phase(input int count, input bit pause_mid);
        int  start;
        int  pick;
        bit  paused;
        start  = bytes_fed;
        paused = 1'b0;
        while (bytes_fed - start < count)
        begin
            script.delete();
            pick = $urandom_range(0, 19);
            if (pick < 14)
                compose_row(board.delim);
            else if (pick < 17)
                compose_noise();
            else
                compose_broken(board.delim);
            foreach (script[i])
                push_beat(script[i][7:0], script[i][8]);
            if (pause_mid && !paused && bytes_fed - start >= count / 2)
            begin
                settle();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] delims[$];
        delims = '{8'd59, 8'd0, CH_QUOTE, 8'd255, CH_CR, CH_LF, 8'd9, DELIM_RESET};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        calm          = 1'b0;
        bytes_fed     = 0;
        board         = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        foreach (delims[i])
        begin
            settle();
            write_delimiter(delims[i]);
            if (i == delims.size() - 1)
                calm = 1'b1;
            run_phase(100, i == 1);
        end
        settle();
        repeat (20) @(negedge clk);
        if (board.fails == 0 && board.awaited.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/csvs_pkg.sv
sv/csvs_parser.sv
sv/csvs_out_queue.sv
sv/csv_stream_field_splitter.sv
sv/csvs_checker.sv
tb/sv/csv_stream_field_splitter_test.sv
